@@ rtl/sosr_pkg.sv @@
package sosr_pkg;

    localparam int GRID_POINTS_DEF = 16;
    localparam int ACC_W           = 48;
    localparam int DIV_STEPS       = 31;

    localparam logic signed [31:0] SYM_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD_EIG = 2'd0,
        OP_LOAD_VEC = 2'd1,
        OP_LOAD_RHS = 2'd2,
        OP_COMPUTE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_SINGULAR = 2'd1,
        STS_INVALID  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_OCC_COUNT = 2'd0,
        CFG_OCC_INDEX = 2'd1,
        CFG_OMEGA     = 2'd2,
        CFG_VOLUME    = 2'd3
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_IDLE, S_CHK, S_EOCC, S_SCAN_RD, S_SCAN_CK,
        S_DOT_RD, S_DOT_M0, S_DOT_M1, S_DOT_M2, S_DOT_M3, S_DOT_M4,
        S_SC0, S_SC1, S_SC2,
        S_DN0, S_DN1, S_DN2, S_DN3, S_DN4, S_DN5, S_DN6,
        S_DIVR_GO, S_DIVR_WT, S_DIVI_GO, S_DIVI_WT,
        S_AC_RD, S_AC0, S_AC1, S_AC2, S_AC3, S_AC4,
        S_OUT
    } t_state;

    // clamp to the symmetric 32-bit range
    function automatic logic signed [31:0] csym64(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = SYM_MAX;
        end else if (x < 64'shFFFF_FFFF_8000_0001) begin
            r = -SYM_MAX;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] csym32(input logic signed [31:0] x);
        logic signed [31:0] r;
        if (x == 32'sh8000_0000) begin
            r = -SYM_MAX;
        end else begin
            r = x;
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] x);
        logic signed [ACC_W-1:0] r;
        if (x > 49'sh0_7FFF_FFFF_FFFF) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (x < 49'sh1_8000_0000_0000) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = x[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if (x > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < 48'shFFFF_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/sum_over_states_response.sv @@
// channel     direction  handshake                    payload
// request     in         start & !busy                i_op, i_state_number, i_point_number,
//                                                     i_value_real, i_value_imag
// config      in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
// result      out        o_result_valid, one cycle    o_point_out, o_response_real,
//                                                     o_response_imag, o_status, o_last
//
// loads keep busy low. a compute keeps busy high while it runs on the one shared
// 32x32 multiplier (four products per grid point in each pass) and the bit-serial
// divider (two quotients per state, a quotient that saturates ending early).
// results leave one per cycle at the end of the run and cannot be stalled.
// reset clears the state, the result valid and configuration; stores stay undefined until loaded.
module sum_over_states_response #(
    parameter int GRID_POINTS = sosr_pkg::GRID_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [5:0]         i_state_number,
    input  logic [5:0]         i_point_number,
    input  logic signed [31:0] i_value_real,
    input  logic signed [31:0] i_value_imag,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_result_valid,
    output logic [5:0]         o_point_out,
    output logic signed [31:0] o_response_real,
    output logic signed [31:0] o_response_imag,
    output logic [1:0]         o_status,
    output logic               o_last
);
    import sosr_pkg::*;

    localparam int AW  = $clog2(GRID_POINTS);
    localparam int VAW = $clog2(GRID_POINTS * GRID_POINTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(GRID_POINTS - 1);

    // configuration
    logic [5:0]  r_oc;
    logic [5:0]  r_oi;
    logic [30:0] r_omega;
    logic [30:0] r_ve;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc    <= 6'd1;
            r_oi    <= 6'd0;
            r_omega <= '0;
            r_ve    <= 31'd65536;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OCC_COUNT: r_oc    <= i_cfg_data[5:0];
                CFG_OCC_INDEX: r_oi    <= i_cfg_data[5:0];
                CFG_OMEGA:     r_omega <= i_cfg_data[30:0];
                CFG_VOLUME:    r_ve    <= i_cfg_data[30:0];
                default:       r_oc    <= r_oc;
            endcase
        end
    end

    // control registers
    t_state  r_state, n_state;
    logic [AW-1:0] r_s, n_s;
    logic [AW-1:0] r_p, n_p;
    logic signed [31:0] r_eocc, n_eocc;
    logic signed [63:0] r_sr, n_sr;
    logic signed [63:0] r_si, n_si;
    logic signed [63:0] r_t, n_t;
    logic signed [31:0] r_a, n_a;
    logic signed [31:0] r_b, n_b;
    logic signed [31:0] r_c, n_c;
    logic [63:0]        r_den, n_den;
    logic signed [63:0] r_numr, n_numr;
    logic signed [63:0] r_numi, n_numi;
    logic signed [31:0] r_cr, n_cr;
    logic signed [31:0] r_ci, n_ci;
    logic signed [ACC_W-1:0] r_tr, n_tr;
    logic signed [63:0] r_prod;

    logic               r_valid, n_valid;
    logic [5:0]         r_point, n_point;
    logic signed [31:0] r_rre, n_rre;
    logic signed [31:0] r_rim, n_rim;
    logic [1:0]         r_sts, n_sts;
    logic               r_last, n_last;

    // stores
    logic [31:0] r_ev_mem  [GRID_POINTS];
    logic [63:0] r_vec_mem [GRID_POINTS * GRID_POINTS];
    logic [63:0] r_rhs_mem [GRID_POINTS];
    logic [31:0] r_ev_rd;
    logic [63:0] r_vec_rd;
    logic [63:0] r_rhs_rd;

    logic            accept;
    logic [AW-1:0]   ev_addr;
    logic [VAW-1:0]  vec_addr;
    logic [VAW-1:0]  vec_waddr;
    logic            sn_ok;
    logic            pn_ok;

    assign accept    = start && !busy;
    assign sn_ok     = {1'b0, i_state_number} < 7'(GRID_POINTS);
    assign pn_ok     = {1'b0, i_point_number} < 7'(GRID_POINTS);
    assign ev_addr   = (r_state == S_CHK) ? AW'(r_oi) : r_s;
    assign vec_addr  = VAW'(r_s) * VAW'(GRID_POINTS) + VAW'(r_p);
    assign vec_waddr = VAW'(i_state_number) * VAW'(GRID_POINTS) + VAW'(i_point_number);

    always_ff @(posedge i_clk) begin
        if (accept && t_op'(i_op) == OP_LOAD_EIG && sn_ok) begin
            r_ev_mem[AW'(i_state_number)] <= i_value_real;
        end
        r_ev_rd <= r_ev_mem[ev_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_op'(i_op) == OP_LOAD_VEC && sn_ok && pn_ok) begin
            r_vec_mem[vec_waddr] <= {i_value_imag, i_value_real};
        end
        r_vec_rd <= r_vec_mem[vec_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_op'(i_op) == OP_LOAD_RHS && pn_ok) begin
            r_rhs_mem[AW'(i_point_number)] <= {i_value_imag, i_value_real};
        end
        r_rhs_rd <= r_rhs_mem[r_p];
    end

    // operands, clamped symmetric
    logic signed [31:0] vr, vi, rr, ri, ve_s, om_s;
    assign vr   = csym32(r_vec_rd[31:0]);
    assign vi   = csym32(r_vec_rd[63:32]);
    assign rr   = csym32(r_rhs_rd[31:0]);
    assign ri   = csym32(r_rhs_rd[63:32]);
    assign ve_s = signed'({1'b0, r_ve});
    assign om_s = signed'({1'b0, r_omega});

    // shared multiplier, registered product
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    // divider
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quot;

    sosr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ((r_state == S_DIVI_GO) ? r_numi : r_numr),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // accumulator ring
    logic signed [ACC_W-1:0] cell_re [GRID_POINTS];
    logic signed [ACC_W-1:0] cell_im [GRID_POINTS];
    logic signed [ACC_W-1:0] ring_re, ring_im;
    logic ring_shift, ring_clr;

    for (genvar k = 0; k < GRID_POINTS; k++) begin : g_cell
        if (k == 0) begin : g_head
            sosr_cell u_cell (
                .i_clk   (i_clk),
                .i_clr   (ring_clr),
                .i_shift (ring_shift),
                .i_re    (ring_re),
                .i_im    (ring_im),
                .o_re    (cell_re[k]),
                .o_im    (cell_im[k])
            );
        end else begin : g_body
            sosr_cell u_cell (
                .i_clk   (i_clk),
                .i_clr   (ring_clr),
                .i_shift (ring_shift),
                .i_re    (cell_re[k-1]),
                .i_im    (cell_im[k-1]),
                .o_re    (cell_re[k]),
                .o_im    (cell_im[k])
            );
        end
    end

    logic signed [ACC_W-1:0] tail_re, tail_im;
    assign tail_re = cell_re[GRID_POINTS-1];
    assign tail_im = cell_im[GRID_POINTS-1];

    logic signed [32:0] ev_diff;
    logic signed [63:0] fl_sum, fl_dif, fl_prod;
    logic signed [ACC_W-1:0] ti;
    logic invalid;

    assign ev_diff = {r_ev_rd[31], r_ev_rd} - {r_eocc[31], r_eocc};
    assign fl_sum  = (r_t + r_prod) >>> 16;
    assign fl_dif  = (r_t - r_prod) >>> 16;
    assign fl_prod = r_prod >>> 16;
    assign ti      = fl_sum[ACC_W-1:0];
    assign invalid = (r_oc == 6'd0) || ({1'b0, r_oc} >= 7'(GRID_POINTS)) ||
                     (r_oi >= r_oc) || (r_ve == 31'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_p     <= n_p;
        r_eocc  <= n_eocc;
        r_sr    <= n_sr;
        r_si    <= n_si;
        r_t     <= n_t;
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_den   <= n_den;
        r_numr  <= n_numr;
        r_numi  <= n_numi;
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_tr    <= n_tr;
        r_point <= n_point;
        r_rre   <= n_rre;
        r_rim   <= n_rim;
        r_sts   <= n_sts;
        r_last  <= n_last;
    end

    always_comb begin
        n_state    = r_state;
        n_s        = r_s;
        n_p        = r_p;
        n_eocc     = r_eocc;
        n_sr       = r_sr;
        n_si       = r_si;
        n_t        = r_t;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_den      = r_den;
        n_numr     = r_numr;
        n_numi     = r_numi;
        n_cr       = r_cr;
        n_ci       = r_ci;
        n_tr       = r_tr;
        n_valid    = 1'b0;
        n_point    = r_point;
        n_rre      = r_rre;
        n_rim      = r_rim;
        n_sts      = r_sts;
        n_last     = r_last;
        mul_a      = vr;
        mul_b      = rr;
        div_start  = 1'b0;
        ring_shift = 1'b0;
        ring_clr   = 1'b0;
        ring_re    = sat48({tail_re[ACC_W-1], tail_re} + {r_tr[ACC_W-1], r_tr});
        ring_im    = sat48({tail_im[ACC_W-1], tail_im} + {ti[ACC_W-1], ti});

        case (r_state)
            S_IDLE: begin
                if (accept && t_op'(i_op) == OP_COMPUTE) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (invalid) begin
                    n_valid = 1'b1;
                    n_point = '0;
                    n_rre   = '0;
                    n_rim   = '0;
                    n_sts   = STS_INVALID;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EOCC;
                end
            end
            S_EOCC: begin
                n_eocc  = r_ev_rd;
                n_s     = AW'(r_oc);
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: n_state = S_SCAN_CK;
            S_SCAN_CK: begin
                if (r_omega == 31'd0 && r_ev_rd == r_eocc) begin
                    n_valid = 1'b1;
                    n_point = '0;
                    n_rre   = '0;
                    n_rim   = '0;
                    n_sts   = STS_SINGULAR;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_s == LAST_IDX) begin
                    n_s      = AW'(r_oc);
                    n_p      = '0;
                    n_sr     = '0;
                    n_si     = '0;
                    ring_clr = 1'b1;
                    n_state  = S_DOT_RD;
                end else begin
                    n_s     = r_s + AW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            // conjugate dot product of the state with the rhs
            S_DOT_RD: n_state = S_DOT_M0;
            S_DOT_M0: begin
                mul_a   = vr;
                mul_b   = rr;
                n_state = S_DOT_M1;
            end
            S_DOT_M1: begin
                mul_a   = vi;
                mul_b   = ri;
                n_t     = r_prod;
                n_state = S_DOT_M2;
            end
            S_DOT_M2: begin
                mul_a   = vr;
                mul_b   = ri;
                n_sr    = r_sr + fl_sum;
                n_state = S_DOT_M3;
            end
            S_DOT_M3: begin
                mul_a   = vi;
                mul_b   = rr;
                n_t     = r_prod;
                n_state = S_DOT_M4;
            end
            S_DOT_M4: begin
                n_si = r_si + fl_dif;
                if (r_p == LAST_IDX) begin
                    n_state = S_SC0;
                end else begin
                    n_p     = r_p + AW'(1);
                    n_state = S_DOT_RD;
                end
            end
            // volume scaling, then the denominator and both numerator parts
            S_SC0: begin
                mul_a   = csym64(r_sr);
                mul_b   = ve_s;
                n_state = S_SC1;
            end
            S_SC1: begin
                mul_a   = csym64(r_si);
                mul_b   = ve_s;
                n_a     = csym64(fl_prod);
                n_state = S_SC2;
            end
            S_SC2: begin
                n_b     = csym64(fl_prod);
                n_c     = csym64(64'(ev_diff));
                n_state = S_DN0;
            end
            S_DN0: begin
                mul_a   = r_c;
                mul_b   = r_c;
                n_state = S_DN1;
            end
            S_DN1: begin
                mul_a   = om_s;
                mul_b   = om_s;
                n_den   = r_prod;
                n_state = S_DN2;
            end
            S_DN2: begin
                mul_a   = r_a;
                mul_b   = r_c;
                n_den   = r_den + r_prod;
                n_state = S_DN3;
            end
            S_DN3: begin
                mul_a   = r_b;
                mul_b   = om_s;
                n_t     = r_prod;
                n_state = S_DN4;
            end
            S_DN4: begin
                mul_a   = r_b;
                mul_b   = r_c;
                n_numr  = r_t + r_prod;
                n_state = S_DN5;
            end
            S_DN5: begin
                mul_a   = r_a;
                mul_b   = om_s;
                n_t     = r_prod;
                n_state = S_DN6;
            end
            S_DN6: begin
                n_numi  = r_t - r_prod;
                n_state = S_DIVR_GO;
            end
            S_DIVR_GO: begin
                div_start = 1'b1;
                n_state   = S_DIVR_WT;
            end
            S_DIVR_WT: begin
                if (div_done) begin
                    n_cr    = div_quot;
                    n_state = S_DIVI_GO;
                end
            end
            S_DIVI_GO: begin
                div_start = 1'b1;
                n_state   = S_DIVI_WT;
            end
            S_DIVI_WT: begin
                if (div_done) begin
                    n_ci    = div_quot;
                    n_p     = '0;
                    n_state = S_AC_RD;
                end
            end
            // quotient times state, added around the ring
            S_AC_RD: n_state = S_AC0;
            S_AC0: begin
                mul_a   = r_cr;
                mul_b   = vr;
                n_state = S_AC1;
            end
            S_AC1: begin
                mul_a   = r_ci;
                mul_b   = vi;
                n_t     = r_prod;
                n_state = S_AC2;
            end
            S_AC2: begin
                mul_a   = r_cr;
                mul_b   = vi;
                n_tr    = fl_dif[ACC_W-1:0];
                n_state = S_AC3;
            end
            S_AC3: begin
                mul_a   = r_ci;
                mul_b   = vr;
                n_t     = r_prod;
                n_state = S_AC4;
            end
            S_AC4: begin
                ring_shift = 1'b1;
                if (r_p == LAST_IDX) begin
                    n_p = '0;
                    if (r_s == LAST_IDX) begin
                        n_state = S_OUT;
                    end else begin
                        n_s     = r_s + AW'(1);
                        n_sr    = '0;
                        n_si    = '0;
                        n_state = S_DOT_RD;
                    end
                end else begin
                    n_p     = r_p + AW'(1);
                    n_state = S_AC_RD;
                end
            end
            S_OUT: begin
                ring_shift = 1'b1;
                ring_re    = '0;
                ring_im    = '0;
                n_valid    = 1'b1;
                n_point    = 6'(r_p);
                n_rre      = sat32(tail_re);
                n_rim      = sat32(tail_im);
                n_sts      = STS_OK;
                n_last     = (r_p == LAST_IDX);
                if (r_p == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_p = r_p + AW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_valid  = r_valid;
    assign o_point_out     = r_point;
    assign o_response_real = r_rre;
    assign o_response_imag = r_rim;
    assign o_status        = r_sts;
    assign o_last          = r_last;

endmodule

@@ rtl/sosr_cell.sv @@
module sosr_cell (
    input  logic                              i_clk,
    input  logic                              i_clr,
    input  logic                              i_shift,
    input  logic signed [sosr_pkg::ACC_W-1:0] i_re,
    input  logic signed [sosr_pkg::ACC_W-1:0] i_im,
    output logic signed [sosr_pkg::ACC_W-1:0] o_re,
    output logic signed [sosr_pkg::ACC_W-1:0] o_im
);
    import sosr_pkg::*;

    logic signed [ACC_W-1:0] r_re;
    logic signed [ACC_W-1:0] r_im;

    // one grid point's accumulator, passed along the ring on each shift
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_re <= '0;
            r_im <= '0;
        end else if (i_shift) begin
            r_re <= i_re;
            r_im <= i_im;
        end
    end

    assign o_re = r_re;
    assign o_im = r_im;

endmodule

@@ rtl/sosr_div.sv @@
module sosr_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic        [63:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    import sosr_pkg::*;

    logic        r_run;
    logic        r_first;
    logic        r_neg;
    logic [63:0] r_den;
    logic [63:0] r_rem;
    logic [15:0] r_low;
    logic [4:0]  r_cnt;
    logic [30:0] r_q;
    logic        r_done;
    logic signed [31:0] r_quot;

    logic [63:0] mag;
    logic        xbit;
    logic [64:0] sh;
    logic [64:0] diff;
    logic        ge;

    assign mag  = i_num[63] ? (64'd0 - i_num) : i_num;
    // dividend is mag shifted up 16, so mag's low bits feed the early steps and zeros the later ones
    assign xbit = r_cnt[4] ? r_low[r_cnt[3:0]] : 1'b0;
    assign sh   = {r_rem, xbit};
    assign diff = sh - {1'b0, r_den};
    assign ge   = !diff[64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run   <= 1'b1;
                r_first <= 1'b1;
                r_neg   <= i_num[63];
                r_den   <= i_den;
                r_rem   <= mag >> 15;
                r_low   <= {1'b0, mag[14:0]};
                r_cnt   <= 5'(DIV_STEPS - 1);
                r_q     <= '0;
            end else if (r_run) begin
                if (r_first) begin
                    r_first <= 1'b0;
                    // integer part of 2^15 or more saturates
                    if (r_rem >= r_den) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                        r_quot <= r_neg ? -SYM_MAX : SYM_MAX;
                    end
                end else begin
                    r_rem <= ge ? diff[63:0] : sh[63:0];
                    r_q   <= {r_q[29:0], ge};
                    if (r_cnt == 5'd0) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                        r_quot <= r_neg ? -signed'({1'b0, r_q[29:0], ge})
                                        : signed'({1'b0, r_q[29:0], ge});
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ rtl/sosr_checker.sv @@
module sosr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_op,
    input logic               o_result_valid,
    input logic [5:0]         o_point_out,
    input logic signed [31:0] o_response_real,
    input logic [1:0]         o_status,
    input logic               o_last
);
    import sosr_pkg::*;

    // a load request never makes the block busy
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op != OP_COMPUTE |=> !busy)
        else $error("load request left the block busy");

    // every result comes out of a compute run
    a_result_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result outside a compute run");

    // an error result is a lone zero result at point zero
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_status != STS_OK |->
            o_last && o_point_out == 6'd0 && o_response_real == 32'sd0)
        else $error("malformed error result");

    // ok results walk the grid points one per cycle until last
    a_point_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_status == STS_OK && !o_last |=>
            o_result_valid && o_point_out == $past(o_point_out) + 6'd1)
        else $error("grid points not consecutive");

endmodule

bind sum_over_states_response sosr_checker u_sosr_checker (.*);
